@@ rtl/dpdma_pkg.sv @@
// ----------------------------------------------------------------------------
// dpdma_pkg
// Types, codes and helper functions shared by the two-port DMA engine.
// ----------------------------------------------------------------------------
package dpdma_pkg;

  localparam int FifoDepth  = 16;
  localparam int BlockBytes = 64;
  localparam int BeatBytes  = 8;
  localparam int RqDepth    = 4;

  localparam int QAW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int QCW = $clog2(FifoDepth + 1);
  localparam int BOW = $clog2(BlockBytes);
  localparam int RAW = $clog2(RqDepth);
  localparam int RCW = $clog2(RqDepth + 1);

  typedef enum logic [1:0] {
    CMD_REG_RD     = 2'd0,
    CMD_REG_WR     = 2'd1,
    CMD_MEM_RD_RSP = 2'd2,
    CMD_MEM_WR_RSP = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_REG_RSP    = 2'd0,
    KIND_MEM_RD_REQ = 2'd1,
    KIND_MEM_WR_REQ = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    RES_OK        = 2'd0,
    RES_ADDR_ERR  = 2'd1,
    RES_CMD_ERR   = 2'd2,
    RES_BURST_ERR = 2'd3
  } res_t;

  typedef enum logic [2:0] {
    REG_START  = 3'd0,
    REG_ADDR0  = 3'd1,
    REG_ADDR1  = 3'd2,
    REG_SIZE   = 3'd3,
    REG_STATUS = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_BUSY    = 3'd1,
    ST_DONE    = 3'd2,
    ST_BUSERR  = 3'd3,
    ST_INVALID = 3'd4
  } status_t;

  typedef struct packed {
    kind_t       kind;
    res_t        result;
    logic [63:0] read_value;
    logic        port;
    logic [63:0] addr;
    logic [3:0]  len;
    logic [63:0] data;
    logic        last;
  } res_item_t;

  typedef struct packed {
    logic [1:0] n;
    res_item_t  item0;
    res_item_t  item1;
  } res_push_t;

  // Beat length: remaining bytes, beat size, and room left in both blocks.
  function automatic logic [3:0] beat_len(logic [63:0] left, logic [63:0] ra,
                                          logic [63:0] wa);
    logic [BOW:0] n;
    logic [BOW:0] rroom;
    logic [BOW:0] wroom;
    n     = (left < 64'(BeatBytes)) ? left[BOW:0] : (BOW+1)'(BeatBytes);
    rroom = (BOW+1)'(BlockBytes) - {1'b0, ra[BOW-1:0]};
    wroom = (BOW+1)'(BlockBytes) - {1'b0, wa[BOW-1:0]};
    if (rroom < n) n = rroom;
    if (wroom < n) n = wroom;
    return 4'(n);
  endfunction

  function automatic logic [63:0] byte_mask(logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < len) m[b*8 +: 8] = 8'hff;
    end
    return m;
  endfunction

endpackage

@@ rtl/dpdma_ctrl.sv @@
// ----------------------------------------------------------------------------
// dpdma_ctrl
// Front end: decodes transactions, keeps the registers and the beat FIFO,
// and forms up to two results per transaction.
// ----------------------------------------------------------------------------
module dpdma_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic [1:0]           cmd,
  input  logic [2:0]           reg_index,
  input  logic [3:0]           access_bytes,
  input  logic [63:0]          write_value,
  input  logic [63:0]          mem_read_data,
  input  logic                 resp_ok,
  output dpdma_pkg::res_push_t push
);
  import dpdma_pkg::*;

  logic            start_r, start_nxt;
  logic [63:0]     addr0_r, addr0_nxt, addr1_r, addr1_nxt, size_r, size_nxt;
  status_t         status_r, status_nxt;
  logic            busy_r, busy_nxt, rev_r, rev_nxt, failed_r, failed_nxt;
  logic [63:0]     left_r, left_nxt, wcur_r, wcur_nxt;
  logic [QAW-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [QCW-1:0]  count_r, count_nxt;
  logic            rdp_r, rdp_nxt, wrp_r, wrp_nxt;

  logic [63:0]     q_data [FifoDepth];
  logic [3:0]      q_len  [FifoDepth];

  logic            do_push;
  logic [63:0]     push_data;
  logic [3:0]      push_len;

  function automatic logic [QAW-1:0] inc(logic [QAW-1:0] p);
    return (p == QAW'(FifoDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    res_item_t   it [2];
    res_item_t   rsp;
    logic [1:0]  n;
    logic        issue_en;
    logic        quiet_chk;
    logic [3:0]  len;
    logic [63:0] hd_data;
    logic [3:0]  hd_len;
    logic [63:0] ra, wa;

    start_nxt  = start_r;   addr0_nxt = addr0_r;  addr1_nxt = addr1_r;
    size_nxt   = size_r;    status_nxt = status_r; busy_nxt = busy_r;
    rev_nxt    = rev_r;     failed_nxt = failed_r; left_nxt = left_r;
    wcur_nxt   = wcur_r;    head_nxt = head_r;     tail_nxt = tail_r;
    count_nxt  = count_r;   rdp_nxt = rdp_r;       wrp_nxt = wrp_r;
    it[0] = '0; it[1] = '0; rsp = '0; n = '0;
    issue_en = 1'b0; quiet_chk = 1'b0;
    do_push = 1'b0; push_len = '0; push_data = '0;
    len = '0; hd_data = '0; hd_len = '0; ra = '0; wa = '0;
    rsp.kind = KIND_REG_RSP;
    rsp.result = RES_OK;

    if (in_fire) begin
      unique case (cmd_t'(cmd))
        CMD_REG_RD: begin
          if (access_bytes != 4'd8) rsp.result = RES_BURST_ERR;
          else begin
            case (reg_idx_t'(reg_index))
              REG_START:  rsp.read_value = 64'(start_r);
              REG_ADDR0:  rsp.read_value = addr0_r;
              REG_ADDR1:  rsp.read_value = addr1_r;
              REG_SIZE:   rsp.read_value = size_r;
              REG_STATUS: rsp.read_value = 64'(status_r);
              default:    rsp.result = RES_ADDR_ERR;
            endcase
          end
          it[0] = rsp; n = 2'd1;
        end
        CMD_REG_WR: begin
          if (access_bytes != 4'd8) rsp.result = RES_BURST_ERR;
          else if (busy_r) rsp.result = RES_CMD_ERR;
          else begin
            case (reg_idx_t'(reg_index))
              REG_START: begin
                start_nxt = (write_value != '0);
                if (write_value != '0) begin
                  if (size_r == '0) begin
                    start_nxt  = 1'b0;
                    status_nxt = ST_DONE;
                  end else if (size_r == {1'b1, 63'd0}) begin
                    start_nxt  = 1'b0;
                    status_nxt = ST_INVALID;
                    rsp.result = RES_CMD_ERR;
                  end else begin
                    rev_nxt    = size_r[63];
                    size_nxt   = size_r[63] ? (64'd0 - size_r) : size_r;
                    failed_nxt = 1'b0;
                    status_nxt = ST_BUSY;
                    busy_nxt   = 1'b1;
                    left_nxt   = size_nxt;
                    wcur_nxt   = size_r[63] ? addr0_r : addr1_r;
                    count_nxt  = '0;
                    tail_nxt   = head_r;
                    rdp_nxt    = 1'b0;
                    wrp_nxt    = 1'b0;
                    issue_en   = 1'b1;
                  end
                end
              end
              REG_ADDR0:  addr0_nxt = write_value;
              REG_ADDR1:  addr1_nxt = write_value;
              REG_SIZE:   size_nxt = write_value;
              REG_STATUS: rsp.result = RES_CMD_ERR;
              default:    rsp.result = RES_ADDR_ERR;
            endcase
          end
          it[0] = rsp; n = 2'd1;
        end
        CMD_MEM_RD_RSP: begin
          if (busy_r && rdp_r) begin
            rdp_nxt = 1'b0;
            if (failed_r) quiet_chk = 1'b1;
            else if (!resp_ok) begin
              failed_nxt = 1'b1;
              status_nxt = ST_BUSERR;
              // keep only the beat whose write is outstanding
              count_nxt  = QCW'(wrp_r);
              tail_nxt   = wrp_r ? inc(head_r) : head_r;
              quiet_chk  = 1'b1;
            end else begin
              len = beat_len(left_r, rev_r ? addr1_r : addr0_r, wcur_r);
              if (count_r < QCW'(FifoDepth)) begin
                do_push   = 1'b1;
                push_len  = len;
                push_data = mem_read_data & byte_mask(len);
                count_nxt = count_r + 1'b1;
                tail_nxt  = inc(tail_r);
              end
              if (rev_r) addr1_nxt = addr1_r + 64'(len);
              else       addr0_nxt = addr0_r + 64'(len);
              wcur_nxt = wcur_r + 64'(len);
              left_nxt = left_r - 64'(len);
              issue_en = 1'b1;
            end
          end
        end
        CMD_MEM_WR_RSP: begin
          if (busy_r && wrp_r && count_r != '0) begin
            wrp_nxt   = 1'b0;
            len       = q_len[head_r];
            head_nxt  = inc(head_r);
            count_nxt = count_r - 1'b1;
            if (!resp_ok) begin
              failed_nxt = 1'b1;
              status_nxt = ST_BUSERR;
              count_nxt  = '0;
              tail_nxt   = head_nxt;
              quiet_chk  = 1'b1;
            end else begin
              if (rev_r) addr0_nxt = addr0_r + 64'(len);
              else       addr1_nxt = addr1_r + 64'(len);
              if (failed_r) quiet_chk = 1'b1;
              else if (64'(len) >= size_r) begin
                status_nxt = ST_DONE; busy_nxt = 1'b0; start_nxt = 1'b0;
                size_nxt = '0; left_nxt = '0; count_nxt = '0;
                tail_nxt = head_nxt; rdp_nxt = 1'b0; wrp_nxt = 1'b0;
              end else begin
                size_nxt = size_r - 64'(len);
                issue_en = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end

    // stop once every outstanding request of a failed transfer has answered
    if (quiet_chk && !rdp_nxt && !wrp_nxt) begin
      status_nxt = ST_BUSERR; busy_nxt = 1'b0; start_nxt = 1'b0;
      size_nxt = '0; left_nxt = '0; count_nxt = '0;
      tail_nxt = head_nxt; rdp_nxt = 1'b0; wrp_nxt = 1'b0;
    end

    if (issue_en) begin
      ra = rev_nxt ? addr1_nxt : addr0_nxt;
      wa = rev_nxt ? addr0_nxt : addr1_nxt;
      if (do_push && count_r == '0) begin
        hd_data = push_data; hd_len = push_len;
      end else begin
        hd_data = q_data[head_nxt]; hd_len = q_len[head_nxt];
      end
      if (!wrp_nxt && count_nxt != '0) begin
        it[n[0]]      = '0;
        it[n[0]].kind = KIND_MEM_WR_REQ;
        it[n[0]].port = ~rev_nxt;
        it[n[0]].addr = wa;
        it[n[0]].len  = hd_len;
        it[n[0]].data = hd_data;
        n = n + 1'b1;
        wrp_nxt = 1'b1;
      end
      if (!rdp_nxt && left_nxt != '0 && count_nxt < QCW'(FifoDepth)) begin
        it[n[0]]      = '0;
        it[n[0]].kind = KIND_MEM_RD_REQ;
        it[n[0]].port = rev_nxt;
        it[n[0]].addr = ra;
        it[n[0]].len  = beat_len(left_nxt, ra, wcur_nxt);
        n = n + 1'b1;
        rdp_nxt = 1'b1;
      end
    end

    if (n != '0) it[n[0] ^ 1'b1].last = 1'b1;
    push.n     = n;
    push.item0 = it[0];
    push.item1 = it[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 1'b0; addr0_r <= '0; addr1_r <= '0; size_r <= '0;
      status_r <= ST_IDLE; busy_r <= 1'b0; rev_r <= 1'b0; failed_r <= 1'b0;
      left_r <= '0; wcur_r <= '0; head_r <= '0; tail_r <= '0; count_r <= '0;
      rdp_r <= 1'b0; wrp_r <= 1'b0;
    end else begin
      start_r <= start_nxt; addr0_r <= addr0_nxt; addr1_r <= addr1_nxt;
      size_r <= size_nxt; status_r <= status_nxt; busy_r <= busy_nxt;
      rev_r <= rev_nxt; failed_r <= failed_nxt; left_r <= left_nxt;
      wcur_r <= wcur_nxt; head_r <= head_nxt; tail_r <= tail_nxt;
      count_r <= count_nxt; rdp_r <= rdp_nxt; wrp_r <= wrp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_data[tail_r] <= push_data;
      q_len[tail_r]  <= push_len;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCW'(FifoDepth)) else $error("beat FIFO over depth");
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (count_r == '0 && !rdp_r && !wrp_r))
    else $error("idle engine holds beats or requests");
  a_wr_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    wrp_r |-> count_r != '0) else $error("write outstanding without a beat");
  a_reg_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (cmd == CMD_REG_RD || cmd == CMD_REG_WR)) |-> push.n != '0)
    else $error("register transaction without response");

endmodule

@@ rtl/dpdma_rq.sv @@
// ----------------------------------------------------------------------------
// dpdma_rq
// Back end: result queue taking up to two results a cycle and sending one when out_ready.
// ----------------------------------------------------------------------------
module dpdma_rq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dpdma_pkg::res_push_t push,
  output logic                 push_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dpdma_pkg::res_item_t out_item
);
  import dpdma_pkg::*;

  res_item_t       mem [RqDepth];
  logic [RAW-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [RCW-1:0]  count_r, count_nxt;
  logic            pop;

  assign pop        = out_valid && out_ready;
  assign out_valid  = (count_r != '0);
  assign out_item   = mem[head_r];
  assign push_ready = (count_r <= RCW'(RqDepth - 2));

  always_comb begin
    head_nxt  = pop ? head_r + 1'b1 : head_r;
    tail_nxt  = tail_r + RAW'(push.n);
    count_nxt = count_r + RCW'(push.n) - RCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0; tail_r <= '0; count_r <= '0;
    end else begin
      head_r <= head_nxt; tail_r <= tail_nxt; count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != '0) mem[tail_r] <= push.item0;
    if (push.n == 2'd2) mem[tail_r + 1'b1] <= push.item1;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= RCW'(RqDepth)) else $error("result queue overflow");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != '0 |-> push_ready) else $error("push without room");
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && push.n == '0) |=> count_r == $past(count_r) - 1'b1)
    else $error("pop miscount");

endmodule

@@ rtl/dual_port_dma_engine.sv @@
// ----------------------------------------------------------------------------
// dual_port_dma_engine
// Two-port memory-to-memory DMA engine with a 64-bit register interface.
// ----------------------------------------------------------------------------
// Input channel (in_*): register reads/writes and memory responses, kind in
// in_tuser. Output channel (out_*): register responses and memory requests,
// kind in out_tuser, out_tlast on the last result of an input transaction.
// Each input transaction is decoded in the cycle it is accepted and its zero
// to two results enter a four-entry result queue; with the queue empty, the
// first result is on the output in the cycle after acceptance. An input is
// taken every cycle while the queue holds at most two results, so the
// sustained rate is one transaction per cycle for single-result traffic while
// the receiver keeps up; two-result traffic is limited by the single-result
// output port. A stalled receiver fills the result queue and then drops
// in_tready; no result is lost. Reset clears all registers to zero and status
// to idle; the beat FIFO needs no clearing.
// ----------------------------------------------------------------------------
module dual_port_dma_engine (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,  // reg_index, access_bytes, write_value,
                                  // mem_read_data, resp_ok
  input  logic [1:0]   in_tuser,  // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [199:0] out_tdata, // reg_result, read_value, mem_port,
                                  // mem_address, mem_length, mem_data, pad
  output logic [1:0]   out_tuser, // kind
  output logic         out_tlast  // last
);
  import dpdma_pkg::*;

  res_push_t push;
  res_item_t item;
  logic      fire;

  assign fire = in_tvalid && in_tready;

  dpdma_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (fire),
    .cmd           (in_tuser),
    .reg_index     (in_tdata[2:0]),
    .access_bytes  (in_tdata[6:3]),
    .write_value   (in_tdata[70:7]),
    .mem_read_data (in_tdata[134:71]),
    .resp_ok       (in_tdata[135]),
    .push          (push)
  );

  dpdma_rq u_rq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_item   (item)
  );

  assign out_tdata = {1'b0, item.data, item.len, item.addr, item.port,
                      item.read_value, item.result};
  assign out_tuser = item.kind;
  assign out_tlast = item.last;

endmodule

@@ tb/dual_port_dma_engine_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_port_dma_engine_checker
// Watches both stream channels of the DMA engine, predicts the register
// responses and memory requests each input transaction causes, and compares
// every output transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module dual_port_dma_engine_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [135:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [199:0] out_tdata,
  input  logic [1:0]   out_tuser,
  input  logic         out_tlast,
  output int           fail_count,
  output int           pending_count
);
  import dpdma_pkg::*;

  typedef struct {
    kind_t       kind;
    res_t        res;
    logic [63:0] rval;
    logic        port;
    logic [63:0] addr;
    logic [3:0]  len;
    logic [63:0] data;
    logic        lst;
  } dma_result_t;

  dma_result_t expected_results[$];

  // Predicted engine state
  logic        start_flag, busy, rev, failed, rd_pend, wr_pend;
  logic [63:0] addr0, addr1, size, rd_left, wr_cursor;
  status_t     status;
  logic [63:0] beat_data [FifoDepth];
  logic [3:0]  beat_size [FifoDepth];
  int          beat_count;
  int          new_results;

  assign pending_count = expected_results.size();

  function automatic logic [63:0] lane_mask(logic [3:0] len);
    return (len >= 8) ? '1 : ((64'd1 << (len * 8)) - 64'd1);
  endfunction

  function automatic logic [3:0] next_beat_len();
    logic [63:0] ra, n, rroom, wroom;
    ra    = rev ? addr1 : addr0;
    n     = (rd_left < BeatBytes) ? rd_left : 64'(BeatBytes);
    rroom = BlockBytes - (ra % BlockBytes);
    wroom = BlockBytes - (wr_cursor % BlockBytes);
    if (rroom < n) n = rroom;
    if (wroom < n) n = wroom;
    return n[3:0];
  endfunction

  task automatic add_result(kind_t k, res_t r, logic [63:0] rv, logic p,
                            logic [63:0] a, logic [3:0] l, logic [63:0] d);
    dma_result_t e;
    e.kind = k; e.res = r; e.rval = rv; e.port = p;
    e.addr = a; e.len = l; e.data = d; e.lst = 1'b0;
    expected_results.push_back(e);
    new_results++;
  endtask

  task automatic stop_transfer(status_t st);
    status = st; busy = 0; start_flag = 0; size = 0; rd_left = 0;
    beat_count = 0; rd_pend = 0; wr_pend = 0;
  endtask

  task automatic issue_requests();
    if (!busy || failed) return;
    if (!wr_pend && beat_count > 0) begin
      add_result(KIND_MEM_WR_REQ, RES_OK, '0, !rev, rev ? addr0 : addr1,
                 beat_size[0], beat_data[0]);
      wr_pend = 1;
    end
    if (!rd_pend && rd_left > 0 && beat_count < FifoDepth) begin
      add_result(KIND_MEM_RD_REQ, RES_OK, '0, rev, rev ? addr1 : addr0,
                 next_beat_len(), '0);
      rd_pend = 1;
    end
  endtask

  task automatic quiet_stop();
    if (busy && failed && !rd_pend && !wr_pend) stop_transfer(ST_BUSERR);
  endtask

  task automatic predict_transaction(cmd_t cmd, logic [2:0] idx, logic [3:0] ab,
                                     logic [63:0] wv, logic [63:0] rdata, logic ok);
    logic [63:0] v;
    res_t        r;
    logic        started;
    logic [3:0]  l;
    v = '0; r = RES_OK; started = 0;
    new_results = 0;
    case (cmd)
      CMD_REG_RD: begin
        if (ab != 8) r = RES_BURST_ERR;
        else case (idx)
          REG_START:  v = 64'(start_flag);
          REG_ADDR0:  v = addr0;
          REG_ADDR1:  v = addr1;
          REG_SIZE:   v = size;
          REG_STATUS: v = 64'(status);
          default:    r = RES_ADDR_ERR;
        endcase
        add_result(KIND_REG_RSP, r, v, 0, '0, '0, '0);
      end
      CMD_REG_WR: begin
        if (ab != 8) r = RES_BURST_ERR;
        else if (busy) r = RES_CMD_ERR;
        else case (idx)
          REG_START: begin
            start_flag = (wv != 0);
            if (start_flag) begin
              if (size == 0) begin
                start_flag = 0;
                status = ST_DONE;
              end else if (size == {1'b1, 63'd0}) begin
                start_flag = 0;
                status = ST_INVALID;
                r = RES_CMD_ERR;
              end else begin
                rev = size[63];
                if (rev) size = -size;
                failed = 0; status = ST_BUSY; busy = 1;
                rd_left = size;
                wr_cursor = rev ? addr0 : addr1;
                beat_count = 0; rd_pend = 0; wr_pend = 0;
                started = 1;
              end
            end
          end
          REG_ADDR0:  addr0 = wv;
          REG_ADDR1:  addr1 = wv;
          REG_SIZE:   size = wv;
          REG_STATUS: r = RES_CMD_ERR;
          default:    r = RES_ADDR_ERR;
        endcase
        add_result(KIND_REG_RSP, r, '0, 0, '0, '0, '0);
        if (started) issue_requests();
      end
      CMD_MEM_RD_RSP: begin
        if (busy && rd_pend) begin
          rd_pend = 0;
          if (failed) quiet_stop();
          else if (!ok) begin
            failed = 1; status = ST_BUSERR;
            beat_count = wr_pend ? 1 : 0;
            quiet_stop();
          end else begin
            l = next_beat_len();
            if (beat_count < FifoDepth) begin
              beat_data[beat_count] = rdata & lane_mask(l);
              beat_size[beat_count] = l;
              beat_count++;
            end
            if (rev) addr1 += l; else addr0 += l;
            wr_cursor += l;
            rd_left -= l;
            issue_requests();
          end
        end
      end
      default: begin
        if (busy && wr_pend && beat_count > 0) begin
          wr_pend = 0;
          l = beat_size[0];
          for (int i = 1; i < beat_count; i++) begin
            beat_data[i-1] = beat_data[i];
            beat_size[i-1] = beat_size[i];
          end
          beat_count--;
          if (!ok) begin
            failed = 1; status = ST_BUSERR; beat_count = 0;
            quiet_stop();
          end else begin
            if (rev) addr0 += l; else addr1 += l;
            if (failed) quiet_stop();
            else if (64'(l) >= size) stop_transfer(ST_DONE);
            else begin
              size -= l;
              issue_requests();
            end
          end
        end
      end
    endcase
    if (new_results > 0) expected_results[expected_results.size()-1].lst = 1'b1;
  endtask

  always @(posedge clk) begin
    dma_result_t e;
    if (!rst_n) begin
      start_flag = 0; busy = 0; rev = 0; failed = 0; rd_pend = 0; wr_pend = 0;
      addr0 = 0; addr1 = 0; size = 0; rd_left = 0; wr_cursor = 0;
      status = ST_IDLE; beat_count = 0; fail_count = 0;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: unexpected output transaction kind=%0d tdata=%h",
                     out_tuser, out_tdata);
        end else begin
          e = expected_results.pop_front();
          if (out_tuser !== e.kind || out_tdata[1:0] !== e.res ||
              out_tdata[65:2] !== e.rval || out_tdata[66] !== e.port ||
              out_tdata[130:67] !== e.addr || out_tdata[134:131] !== e.len ||
              out_tdata[198:135] !== e.data || out_tlast !== e.lst) begin
            fail_count++;
            if (fail_count <= 10)
              $display("ERROR: mismatch exp kind=%0d res=%0d rv=%h port=%0d ",
                       e.kind, e.res, e.rval, e.port,
                       "addr=%h len=%0d data=%h last=%0d | ",
                       e.addr, e.len, e.data, e.lst,
                       "got kind=%0d res=%0d rv=%h port=%0d ",
                       out_tuser, out_tdata[1:0], out_tdata[65:2], out_tdata[66],
                       "addr=%h len=%0d data=%h last=%0d",
                       out_tdata[130:67], out_tdata[134:131], out_tdata[198:135],
                       out_tlast);
          end
        end
      end
      if (in_tvalid && in_tready)
        predict_transaction(cmd_t'(in_tuser), in_tdata[2:0], in_tdata[6:3],
                            in_tdata[70:7], in_tdata[134:71], in_tdata[135]);
    end
  end

endmodule

@@ tb/dual_port_dma_engine_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_port_dma_engine_test
// Stimulus for the two-port DMA engine: directed register corner cases, then
// random copy transfers in both directions answered by a responder that
// tracks the engine's outstanding memory requests, with bus errors, noise
// accesses and random stalls on both channels.
// ----------------------------------------------------------------------------
module dual_port_dma_engine_test;
  import dpdma_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [135:0] in_tdata;  // reg_index, access_bytes, write_value,
                           // mem_read_data, resp_ok
  logic [1:0]   in_tuser;  // cmd
  logic         out_tvalid;
  logic         out_tready;
  logic [199:0] out_tdata; // reg_result, read_value, mem_port,
                           // mem_address, mem_length, mem_data, pad
  logic [1:0]   out_tuser; // kind
  logic         out_tlast;

  int fail_count;
  int pending_count;
  int items_sent;
  int rd_req_seen, wr_req_seen, rd_rsp_sent, wr_rsp_sent;
  bit no_idle;
  bit hold_done;

  dual_port_dma_engine i_dut (.*);

  dual_port_dma_engine_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL dual_port_dma_engine");
    $finish;
  end

  // Count memory requests the engine has issued
  always @(posedge clk) begin
    if (!rst_n) begin
      rd_req_seen <= 0;
      wr_req_seen <= 0;
    end else if (out_tvalid && out_tready) begin
      if (out_tuser == KIND_MEM_RD_REQ) rd_req_seen <= rd_req_seen + 1;
      if (out_tuser == KIND_MEM_WR_REQ) wr_req_seen <= wr_req_seen + 1;
    end
  end

  // Receiver: random stall bursts, one long hold-off mid run
  initial begin
    int n;
    out_tready = 0;
    hold_done = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && items_sent > 300) begin
        hold_done = 1;
        out_tready = 0;
        repeat (80) @(negedge clk);
      end
      if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_tready = 0;
        n = $urandom_range(1, 6);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_tready = 1;
        n = $urandom_range(1, 12);
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send(cmd_t cmd, logic [2:0] idx, logic [3:0] ab,
                      logic [63:0] wv, logic [63:0] rdata, logic ok);
    int gap;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      in_tvalid = 0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1;
    in_tuser  = cmd;
    in_tdata  = {ok, rdata, wv, ab, idx};
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    items_sent++;
    @(negedge clk);
    in_tvalid = 0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic wait_drained();
    int guard;
    guard = 0;
    while ((pending_count != 0 || guard < 3) && guard < 2000) begin
      @(negedge clk);
      if (pending_count == 0) guard++;
    end
  endtask

  task automatic noise_access();
    cmd_t c;
    logic [3:0] ab;
    c  = ($urandom_range(0, 3) == 0) ? CMD_REG_WR : CMD_REG_RD;
    ab = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
    send(c, 3'($urandom_range(0, 7)), ab, rand64(), rand64(),
         1'($urandom_range(0, 1)));
  endtask

  // Address near a block edge to force short beats
  function automatic logic [63:0] pick_addr();
    logic [63:0] a;
    a = rand64();
    if ($urandom_range(0, 1)) a[5:0] = 6'(64 - $urandom_range(1, 9));
    return a;
  endfunction

  task automatic run_transfer();
    logic [63:0] sz;
    int beats, err_at, k;
    beats  = 0;
    err_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : -1;
    k = $urandom_range(0, 19);
    if (k == 0) begin
      sz = rand64();
      err_at = $urandom_range(0, 20);
    end else if (k == 1) sz = 64'($urandom_range(65, 200));
    else sz = 64'($urandom_range(1, 40));
    if ($urandom_range(0, 1)) sz = -sz;
    send(CMD_REG_WR, REG_ADDR0, 4'd8, pick_addr(), rand64(), 1);
    send(CMD_REG_WR, REG_ADDR1, 4'd8, pick_addr(), rand64(), 1);
    send(CMD_REG_WR, REG_SIZE, 4'd8, sz, rand64(), 1);
    send(CMD_REG_WR, REG_START, 4'd8, rand64() | 64'd1, rand64(), 1);
    forever begin
      if (rd_req_seen == rd_rsp_sent && wr_req_seen == wr_rsp_sent) begin
        wait_drained();
        if (rd_req_seen == rd_rsp_sent && wr_req_seen == wr_rsp_sent) break;
      end
      k = $urandom_range(0, 9);
      if (k < 4 && rd_req_seen != rd_rsp_sent) begin
        rd_rsp_sent++;
        send(CMD_MEM_RD_RSP, 3'($urandom()), 4'($urandom()), rand64(), rand64(),
             !(beats == err_at));
        beats++;
      end else if (k < 8 && wr_req_seen != wr_rsp_sent) begin
        wr_rsp_sent++;
        send(CMD_MEM_WR_RSP, 3'($urandom()), 4'($urandom()), rand64(), rand64(),
             !(beats == err_at));
        beats++;
      end else if (k >= 8 || hold_done == 0) begin
        noise_access();
      end else begin
        @(negedge clk);
      end
    end
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = CMD_REG_RD;
    no_idle = 0;
    items_sent = 0;
    rd_rsp_sent = 0;
    wr_rsp_sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: reset values, bad lengths, unknown and read-only registers
    for (int i = 0; i < 8; i++) send(CMD_REG_RD, 3'(i), 4'd8, '0, '1, 1);
    send(CMD_REG_RD, REG_SIZE, 4'd0, '1, '1, 1);
    send(CMD_REG_WR, REG_ADDR0, 4'd15, '1, '0, 0);
    send(CMD_REG_WR, REG_ADDR1, 4'd7, '1, '0, 0);
    send(CMD_REG_WR, REG_STATUS, 4'd8, '1, '0, 1);
    send(CMD_REG_WR, 3'd7, 4'd8, '1, '0, 1);
    send(CMD_REG_WR, REG_ADDR0, 4'd8, '1, '0, 1);
    send(CMD_REG_WR, REG_ADDR1, 4'd8, '1, '0, 1);
    // Zero size finishes immediately
    send(CMD_REG_WR, REG_START, 4'd8, 64'd1, '0, 1);
    // Minimum signed size is an invalid descriptor
    send(CMD_REG_WR, REG_SIZE, 4'd8, {1'b1, 63'd0}, '0, 1);
    send(CMD_REG_WR, REG_START, 4'd8, '1, '0, 1);
    send(CMD_REG_RD, REG_STATUS, 4'd8, '0, '0, 1);
    // Start with zero value does not start
    send(CMD_REG_WR, REG_START, 4'd8, '0, '0, 1);
    // Responses with nothing outstanding are dropped
    send(CMD_MEM_RD_RSP, '1, '1, '1, '1, 1);
    send(CMD_MEM_WR_RSP, '0, '0, '0, '0, 0);
    send(CMD_REG_RD, REG_START, 4'd8, '0, '0, 1);

    while (items_sent < 1450) begin
      if (items_sent > 1300) no_idle = 1;
      if ($urandom_range(0, 5) == 0) noise_access();
      else run_transfer();
      if (rd_req_seen == rd_rsp_sent && wr_req_seen == wr_rsp_sent &&
          $urandom_range(0, 3) == 0)
        send(cmd_t'($urandom_range(2, 3)), 3'($urandom()), 4'($urandom()),
             rand64(), rand64(), 1'($urandom_range(0, 1)));
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS dual_port_dma_engine");
    end else begin
      $display("FAIL dual_port_dma_engine");
    end
    $finish;
  end

endmodule

@@ dual_port_dma_engine.f @@
rtl/dpdma_pkg.sv
rtl/dpdma_ctrl.sv
rtl/dpdma_rq.sv
rtl/dual_port_dma_engine.sv
tb/dual_port_dma_engine_checker.sv
tb/dual_port_dma_engine_test.sv
